FILE: rtl/core/fxaf_pkg.sv
// fxaf_pkg: shared widths, defaults, command codes and controller/datapath structs
// for the filtered-x LMS anti-noise filter. No dependencies.
`default_nettype none
package fxaf_pkg;

  localparam int CONTROL_TAPS_DEF   = 64;
  localparam int SECONDARY_TAPS_DEF = 32;
  localparam int ERROR_CHANNELS_DEF = 4;

  localparam int SAMPLE_W   = 16;
  localparam int TAP_W      = 32;
  localparam int FR_W       = 24;
  localparam int STEP_W     = 16;
  localparam int COEF_IDX_W = 5;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic load_coef;
    logic push_in;
    logic tap_start;
    logic t_mlo;
    logic t_mhi;
    logic t_full;
    logic t_upd;
    logic t_prod;
    logic y_push;
    logic s_start;
    logic s_src_fid;
    logic s_step;
    logic anti_cap;
    logic fr_push;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic tap_last;
    logic sec_last;
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/fxaf_intf.sv
// fxaf_intf: valid/ready channel interfaces for the sample input and result output.
// Depends on fxaf_pkg for field widths.
`default_nettype none
interface fxaf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   cmd;
  logic signed [fxaf_pkg::SAMPLE_W-1:0]   ref_sample;
  logic signed [fxaf_pkg::SAMPLE_W-1:0]   err_0;
  logic signed [fxaf_pkg::SAMPLE_W-1:0]   err_1;
  logic signed [fxaf_pkg::SAMPLE_W-1:0]   err_2;
  logic signed [fxaf_pkg::SAMPLE_W-1:0]   err_3;
  logic        [fxaf_pkg::COEF_IDX_W-1:0] coef_index;
  logic signed [fxaf_pkg::SAMPLE_W-1:0]   coef_value;

  modport source (output valid, cmd, ref_sample, err_0, err_1, err_2, err_3,
                  coef_index, coef_value, input ready);
  modport sink   (input valid, cmd, ref_sample, err_0, err_1, err_2, err_3,
                  coef_index, coef_value, output ready);
endinterface

interface fxaf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fxaf_pkg::SAMPLE_W-1:0] anti_noise;

  modport source (output valid, anti_noise, input ready);
  modport sink   (input valid, anti_noise, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fxaf_ram.sv
// fxaf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fxaf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/fxaf_ctrl.sv
// fxaf_ctrl: sequencing state machine for the anti-noise filter.
// Depends on fxaf_pkg (dp_cmd_t, dp_sts_t, command codes).
`default_nettype none
module fxaf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_cmd,
  output logic                   in_ready,
  input  wire fxaf_pkg::dp_sts_t sts,
  output fxaf_pkg::dp_cmd_t      cmd
);
  localparam logic [4:0] S_CLR       = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_TSTART    = 5'd2;
  localparam logic [4:0] S_T0        = 5'd3;
  localparam logic [4:0] S_T1        = 5'd4;
  localparam logic [4:0] S_T2        = 5'd5;
  localparam logic [4:0] S_T3        = 5'd6;
  localparam logic [4:0] S_T4        = 5'd7;
  localparam logic [4:0] S_T5        = 5'd8;
  localparam logic [4:0] S_YFIN      = 5'd9;
  localparam logic [4:0] S_YPUSH     = 5'd10;
  localparam logic [4:0] S_OH_START  = 5'd11;
  localparam logic [4:0] S_OH_RUN    = 5'd12;
  localparam logic [4:0] S_OH_DRAIN  = 5'd13;
  localparam logic [4:0] S_ANTI      = 5'd14;
  localparam logic [4:0] S_FID_START = 5'd15;
  localparam logic [4:0] S_FID_RUN   = 5'd16;
  localparam logic [4:0] S_FID_DRAIN = 5'd17;
  localparam logic [4:0] S_FRPUSH    = 5'd18;
  localparam logic [4:0] S_DONE      = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic       acc_in;

  assign in_ready = (state_r == S_IDLE);
  assign acc_in   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc_in) begin
          if (in_cmd == fxaf_pkg::CMD_LOAD) begin
            cmd.load_coef = 1'b1;
          end else begin
            cmd.push_in = 1'b1;
            state_nxt   = S_TSTART;
          end
        end
      end
      S_TSTART: begin
        cmd.tap_start = 1'b1;
        state_nxt     = S_T0;
      end
      S_T0: state_nxt = S_T1;
      S_T1: begin
        cmd.t_mlo = 1'b1;
        state_nxt = S_T2;
      end
      S_T2: begin
        cmd.t_mhi = 1'b1;
        state_nxt = S_T3;
      end
      S_T3: begin
        cmd.t_full = 1'b1;
        state_nxt  = S_T4;
      end
      S_T4: begin
        cmd.t_upd = 1'b1;
        state_nxt = S_T5;
      end
      S_T5: begin
        cmd.t_prod = 1'b1;
        state_nxt  = sts.tap_last ? S_YFIN : S_T0;
      end
      S_YFIN: state_nxt = S_YPUSH;
      S_YPUSH: begin
        cmd.y_push = 1'b1;
        state_nxt  = S_OH_START;
      end
      S_OH_START: begin
        cmd.s_start = 1'b1;
        state_nxt   = S_OH_RUN;
      end
      S_OH_RUN: begin
        cmd.s_step = 1'b1;
        if (sts.sec_last) state_nxt = S_OH_DRAIN;
      end
      S_OH_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_ANTI;
      end
      S_ANTI: begin
        cmd.anti_cap = 1'b1;
        state_nxt    = S_FID_START;
      end
      S_FID_START: begin
        cmd.s_start   = 1'b1;
        cmd.s_src_fid = 1'b1;
        state_nxt     = S_FID_RUN;
      end
      S_FID_RUN: begin
        cmd.s_step = 1'b1;
        if (sts.sec_last) state_nxt = S_FID_DRAIN;
      end
      S_FID_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_FRPUSH;
      end
      S_FRPUSH: begin
        cmd.fr_push = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/fxaf_dp.sv
// fxaf_dp: datapath of the anti-noise filter: state memories, circular pointers,
// the tap-update/output MAC sequence and the secondary-path dot products.
// Depends on fxaf_pkg and fxaf_ram.
`default_nettype none
module fxaf_dp #(
  parameter int CT = fxaf_pkg::CONTROL_TAPS_DEF,
  parameter int ST = fxaf_pkg::SECONDARY_TAPS_DEF,
  parameter int EC = fxaf_pkg::ERROR_CHANNELS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic        [fxaf_pkg::STEP_W-1:0]     cfg_wdata,
  input  wire logic signed [fxaf_pkg::SAMPLE_W-1:0]   in_ref_sample,
  input  wire logic signed [fxaf_pkg::SAMPLE_W-1:0]   in_err_0,
  input  wire logic signed [fxaf_pkg::SAMPLE_W-1:0]   in_err_1,
  input  wire logic signed [fxaf_pkg::SAMPLE_W-1:0]   in_err_2,
  input  wire logic signed [fxaf_pkg::SAMPLE_W-1:0]   in_err_3,
  input  wire logic        [fxaf_pkg::COEF_IDX_W-1:0] in_coef_index,
  input  wire logic signed [fxaf_pkg::SAMPLE_W-1:0]   in_coef_value,
  input  wire fxaf_pkg::dp_cmd_t                      cmd,
  output fxaf_pkg::dp_sts_t                           sts,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [fxaf_pkg::SAMPLE_W-1:0]        out_anti_noise
);
  localparam int TAW  = (CT > 1) ? $clog2(CT) : 1;
  localparam int SAW  = (ST > 1) ? $clog2(ST) : 1;
  localparam int MAXD = (CT > ST) ? CT : ST;
  localparam int CLW  = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int AYW  = 49 + $clog2(CT);
  localparam int ASW  = 36 + $clog2(ST);
  localparam int MW   = ASW + 4;
  localparam int SW   = fxaf_pkg::SAMPLE_W;
  localparam int TW   = fxaf_pkg::TAP_W;
  localparam int FW   = fxaf_pkg::FR_W;
  localparam logic signed [MW-1:0] EC_S = MW'(EC);

  // configuration
  logic [fxaf_pkg::STEP_W-1:0] step_r;

  // pointers and walking addresses
  logic [CLW-1:0] clr_a_r;
  logic [TAW-1:0] rp_r, fp_r, ta_r, fa_r, ra_r;
  logic [SAW-1:0] ip_r, op_r, sa_r, wa_r;
  logic [TAW-1:0] rp_dec, fp_dec;
  logic [SAW-1:0] ip_dec, op_dec;
  logic           src_fid_r;

  // tap sequence
  logic signed [35:0]    p1_r;
  logic signed [42:0]    mlo_r;
  logic signed [41:0]    mhi_r;
  logic signed [60:0]    full;
  logic signed [39:0]    delta_r;
  logic signed [40:0]    diff;
  logic        [TW-1:0]  newtap;
  logic signed [TW-1:0]  newtap_r;
  logic signed [47:0]    prod_r;
  logic                  ya_v_r;
  logic signed [AYW-1:0] acc_y_r;
  logic signed [AYW-1:0] sy;
  logic        [SW-1:0]  yo;

  // stream dot products
  logic                  v1_r, v2_r;
  logic signed [31:0]    sprod_r;
  logic signed [ASW-1:0] acc_s_r;
  logic signed [MW-1:0]  anti_m;
  logic signed [MW-1:0]  anti_sh;
  logic signed [ASW-1:0] hd_sh;
  logic        [FW-1:0]  head;
  logic        [SW-1:0]  anti_r;
  logic                  out_v_r;
  logic        [SW-1:0]  out_d_r;

  // error sum across used channels
  logic signed [18:0] esum;

  // memory ports
  logic [TW-1:0] tap_q;
  logic [FW-1:0] fr_q;
  logic [SW-1:0] ref_q, sec_q, oh_q, fid_q;
  logic          clr_ct, clr_st, coef_ok;
  logic [SAW+4:0] ci_ext;
  logic          tap_we, fr_we, ref_we, fid_we, oh_we, sec_we;
  logic [TAW-1:0] tap_wa, fr_wa, ref_wa;
  logic [SAW-1:0] fid_wa, oh_wa, sec_wa;
  logic [TW-1:0] tap_wd;
  logic [FW-1:0] fr_wd;
  logic [SW-1:0] ref_wd, fid_wd, oh_wd, sec_wd;

  assign rp_dec = (rp_r == '0) ? TAW'(CT - 1) : rp_r - 1'b1;
  assign fp_dec = (fp_r == '0) ? TAW'(CT - 1) : fp_r - 1'b1;
  assign ip_dec = (ip_r == '0) ? SAW'(ST - 1) : ip_r - 1'b1;
  assign op_dec = (op_r == '0) ? SAW'(ST - 1) : op_r - 1'b1;

  assign esum = 19'(in_err_0)
              + ((EC > 1) ? 19'(in_err_1) : 19'sd0)
              + ((EC > 2) ? 19'(in_err_2) : 19'sd0)
              + ((EC > 3) ? 19'(in_err_3) : 19'sd0);

  assign clr_ct  = 32'(clr_a_r) < CT;
  assign clr_st  = 32'(clr_a_r) < ST;
  assign coef_ok = 32'(in_coef_index) < ST;
  assign ci_ext  = (SAW + 5)'(in_coef_index);

  // tap update arithmetic
  assign full = ($signed(61'(mhi_r)) <<< 18) + 61'(mlo_r);
  assign diff = 41'($signed(tap_q)) - 41'(delta_r);
  always_comb begin
    if (&diff[40:31] || ~|diff[40:31]) newtap = diff[31:0];
    else newtap = diff[40] ? 32'h8000_0000 : 32'h7fff_ffff;
  end

  // control output saturation
  assign sy = acc_y_r >>> 28;
  always_comb begin
    if (&sy[AYW-1:15] || ~|sy[AYW-1:15]) yo = sy[15:0];
    else yo = sy[AYW-1] ? 16'h8000 : 16'h7fff;
  end

  assign anti_m  = $signed(MW'(acc_s_r)) * EC_S;
  assign anti_sh = anti_m >>> 15;
  assign hd_sh   = acc_s_r >>> 12;
  always_comb begin
    if (&hd_sh[ASW-1:23] || ~|hd_sh[ASW-1:23]) head = hd_sh[23:0];
    else head = hd_sh[ASW-1] ? 24'h80_0000 : 24'h7f_ffff;
  end

  // memory write selection: clearing pass has precedence
  always_comb begin
    tap_we = cmd.clr_step ? clr_ct : cmd.t_upd;
    tap_wa = cmd.clr_step ? clr_a_r[TAW-1:0] : ta_r;
    tap_wd = cmd.clr_step ? '0 : newtap;
    ref_we = cmd.clr_step ? clr_ct : cmd.push_in;
    ref_wa = cmd.clr_step ? clr_a_r[TAW-1:0] : rp_dec;
    ref_wd = cmd.clr_step ? '0 : in_ref_sample;
    fr_we  = cmd.clr_step ? clr_ct : cmd.fr_push;
    fr_wa  = cmd.clr_step ? clr_a_r[TAW-1:0] : fp_dec;
    fr_wd  = cmd.clr_step ? '0 : head;
    fid_we = cmd.clr_step ? clr_st : cmd.push_in;
    fid_wa = cmd.clr_step ? clr_a_r[SAW-1:0] : ip_dec;
    fid_wd = cmd.clr_step ? '0 : in_ref_sample;
    oh_we  = cmd.clr_step ? clr_st : cmd.y_push;
    oh_wa  = cmd.clr_step ? clr_a_r[SAW-1:0] : op_dec;
    oh_wd  = cmd.clr_step ? '0 : yo;
    sec_we = cmd.clr_step ? clr_st : (cmd.load_coef && coef_ok);
    sec_wa = cmd.clr_step ? clr_a_r[SAW-1:0] : ci_ext[SAW-1:0];
    sec_wd = cmd.clr_step ? '0 : in_coef_value;
  end

  fxaf_ram #(.WIDTH(TW), .DEPTH(CT)) u_tap (
    .clk(clk), .we(tap_we), .waddr(tap_wa), .wdata(tap_wd), .raddr(ta_r), .rdata(tap_q));
  fxaf_ram #(.WIDTH(FW), .DEPTH(CT)) u_fr (
    .clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fa_r), .rdata(fr_q));
  fxaf_ram #(.WIDTH(SW), .DEPTH(CT)) u_ref (
    .clk(clk), .we(ref_we), .waddr(ref_wa), .wdata(ref_wd), .raddr(ra_r), .rdata(ref_q));
  fxaf_ram #(.WIDTH(SW), .DEPTH(ST)) u_fid (
    .clk(clk), .we(fid_we), .waddr(fid_wa), .wdata(fid_wd), .raddr(wa_r), .rdata(fid_q));
  fxaf_ram #(.WIDTH(SW), .DEPTH(ST)) u_oh (
    .clk(clk), .we(oh_we), .waddr(oh_wa), .wdata(oh_wd), .raddr(wa_r), .rdata(oh_q));
  fxaf_ram #(.WIDTH(SW), .DEPTH(ST)) u_sec (
    .clk(clk), .we(sec_we), .waddr(sec_wa), .wdata(sec_wd), .raddr(sa_r), .rdata(sec_q));

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= fxaf_pkg::STEP_RESET;
      clr_a_r   <= '0;
      rp_r      <= '0;
      fp_r      <= '0;
      ip_r      <= '0;
      op_r      <= '0;
      ta_r      <= '0;
      fa_r      <= '0;
      ra_r      <= '0;
      sa_r      <= '0;
      wa_r      <= '0;
      src_fid_r <= 1'b0;
      ya_v_r    <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_we) step_r <= cfg_wdata;
      if (cmd.clr_step) clr_a_r <= clr_a_r + 1'b1;
      if (cmd.push_in) begin
        rp_r <= rp_dec;
        ip_r <= ip_dec;
      end
      if (cmd.y_push) op_r <= op_dec;
      if (cmd.fr_push) fp_r <= fp_dec;
      if (cmd.tap_start) begin
        ta_r <= '0;
        fa_r <= fp_r;
        ra_r <= rp_r;
      end else if (cmd.t_prod) begin
        ta_r <= ta_r + 1'b1;
        fa_r <= (fa_r == TAW'(CT - 1)) ? '0 : fa_r + 1'b1;
        ra_r <= (ra_r == TAW'(CT - 1)) ? '0 : ra_r + 1'b1;
      end
      if (cmd.s_start) begin
        sa_r      <= '0;
        wa_r      <= cmd.s_src_fid ? ip_r : op_r;
        src_fid_r <= cmd.s_src_fid;
      end else if (cmd.s_step) begin
        sa_r <= sa_r + 1'b1;
        wa_r <= (wa_r == SAW'(ST - 1)) ? '0 : wa_r + 1'b1;
      end
      ya_v_r <= cmd.t_prod;
      v1_r   <= cmd.s_step;
      v2_r   <= v1_r;
      if (cmd.out_load) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.push_in) p1_r <= $signed({1'b0, step_r}) * esum;
    if (cmd.t_mlo) mlo_r <= $signed(fr_q) * $signed({1'b0, p1_r[17:0]});
    if (cmd.t_mhi) mhi_r <= $signed(fr_q) * $signed(p1_r[35:18]);
    if (cmd.t_full) delta_r <= full[60:21];
    if (cmd.t_upd) newtap_r <= newtap;
    if (cmd.t_prod) prod_r <= newtap_r * $signed(ref_q);
    if (cmd.tap_start) acc_y_r <= '0;
    else if (ya_v_r) acc_y_r <= acc_y_r + AYW'(prod_r);
    if (v1_r) sprod_r <= $signed(sec_q) * (src_fid_r ? $signed(fid_q) : $signed(oh_q));
    if (cmd.s_start) acc_s_r <= '0;
    else if (v2_r) acc_s_r <= acc_s_r + ASW'(sprod_r);
    if (cmd.anti_cap) begin
      if (&anti_sh[MW-1:15] || ~|anti_sh[MW-1:15]) anti_r <= anti_sh[15:0];
      else anti_r <= anti_sh[MW-1] ? 16'h8000 : 16'h7fff;
    end
    if (cmd.out_load) out_d_r <= anti_r;
  end

  assign sts.clr_last  = (clr_a_r == CLW'(MAXD - 1));
  assign sts.tap_last  = (ta_r == TAW'(CT - 1));
  assign sts.sec_last  = (sa_r == SAW'(ST - 1));
  assign sts.pipe_busy = v1_r || v2_r;
  assign sts.out_free  = !out_v_r || out_ready;

  assign out_valid      = out_v_r;
  assign out_anti_noise = out_d_r;
endmodule
`default_nettype wire

FILE: rtl/core/fxlms_anti_noise_filter_unit.sv
// fxlms_anti_noise_filter_unit: top level of the filtered-x LMS anti-noise filter.
// Depends on fxaf_pkg, fxaf_intf, fxaf_ctrl, fxaf_dp (which uses fxaf_ram).
//
// Usage:
//  - in_ch carries transactions: cmd = load writes one secondary-path coefficient
//    (coef_index, coef_value) and gives no result; cmd = sample runs one full
//    adaptation step and gives exactly one anti_noise transaction on out_ch.
//  - cfg_we/cfg_wdata write the step size; write only while the block is idle.
//  - From its accepting cycle until out_ch.valid rises, a sample runs the single tap
//    MAC sequence (six steps per control tap) and the two streamed secondary-path
//    dot products. One sample is in work at a time; in_ch.ready is high only while
//    the sequencer idles.
//  - After reset a clearing pass zeroes all state memories, during which in_ch.ready
//    stays low; cfg writes are taken.
//  - The result sits in an output register. The next transaction is accepted while
//    it waits; if the receiver still stalls when the next result is ready, hold it
//    in the datapath until the output register frees.
`default_nettype none
module fxlms_anti_noise_filter_unit #(
  parameter int CONTROL_TAPS   = fxaf_pkg::CONTROL_TAPS_DEF,
  parameter int SECONDARY_TAPS = fxaf_pkg::SECONDARY_TAPS_DEF,
  parameter int ERROR_CHANNELS = fxaf_pkg::ERROR_CHANNELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  fxaf_in_if.sink                          in_ch,
  fxaf_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [fxaf_pkg::STEP_W-1:0] cfg_wdata
);
  fxaf_pkg::dp_cmd_t cmd;
  fxaf_pkg::dp_sts_t sts;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  // sequencer: advance through the per-sample schedule
  fxaf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: memories, MAC sequence and output register
  fxaf_dp #(
    .CT (CONTROL_TAPS),
    .ST (SECONDARY_TAPS),
    .EC (ERROR_CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_ref_sample  (in_ch.ref_sample),
    .in_err_0       (in_ch.err_0),
    .in_err_1       (in_ch.err_1),
    .in_err_2       (in_ch.err_2),
    .in_err_3       (in_ch.err_3),
    .in_coef_index  (in_ch.coef_index),
    .in_coef_value  (in_ch.coef_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_anti_noise (out_ch.anti_noise)
  );

`ifndef SYNTHESIS
  // a sample transaction makes the block busy in the next cycle
  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready && in_ch.cmd == fxaf_pkg::CMD_SAMPLE) |=> !in_ready)
    else $error("ready stayed high after a sample transaction");

  // a result appears only when the sequencer loads it
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.out_load))
    else $error("output valid rose without a load");

  // never load over a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten while stalled");
`endif
endmodule
`default_nettype wire
